// ===== sv/aperture_photometry_sums_core_macros.svh =====
// ----------------------------------------------------------------------------
// Aperture photometry sums - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, with the
// active-low reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef APERTURE_PHOTOMETRY_SUMS_CORE_MACROS_SVH
`define APERTURE_PHOTOMETRY_SUMS_CORE_MACROS_SVH

// same-cycle implication
`define APS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/aps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aperture photometry sums - package
// Field widths, register map, reset values and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int SUM_W   = 40;
    localparam int CNT_W   = 25;
    localparam int DIFF_W  = 25;
    localparam int CFG_W   = 16;
    localparam int SIDE_W  = 13;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;

    localparam int MAX_SIDE_DEF   = 4096;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam logic [IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_INNER_RADIUS = 3'd2;
    localparam logic [IDX_W-1:0] REG_OUTER_RADIUS = 3'd3;
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

    localparam logic [CFG_W-1:0]  RST_CENTER_X     = 16'd0;
    localparam logic [CFG_W-1:0]  RST_CENTER_Y     = 16'd0;
    localparam logic [CFG_W-1:0]  RST_INNER_RADIUS = 16'd80;
    localparam logic [CFG_W-1:0]  RST_OUTER_RADIUS = 16'd160;
    localparam logic [SIDE_W-1:0] RST_IMAGE_WIDTH  = 13'd4096;
    localparam logic [SIDE_W-1:0] RST_IMAGE_HEIGHT = 13'd4096;

    typedef struct packed {
        logic ready;
        logic div_start;
        logic div_annulus;
        logic latch_inner;
        logic load_out;
        logic clear;
    } aps_cmd_t;

    typedef struct packed {
        logic end_frame;
        logic acc_done;
        logic empty;
        logic div_done;
        logic out_free;
    } aps_stat_t;

endpackage

// ===== sv/aperture_photometry_sums_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aperture photometry sums - top level
// Circular aperture photometry with a sky annulus over one raster frame,
// with an APB register port for centre, radii and frame size.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_pixel_value
//  m_        out        m_valid / m_ready   sums, counts, mean_difference, flag
//  apb       in         psel/penable/pready centre, radii, frame size
//
//  One pixel beat per cycle within a frame; the distance test is a
//  four-stage pipeline (offset, square, sum and compare, accumulate).
//  After the last beat of a frame intake stalls for the pipeline drain,
//  two mean divisions through one shared divider at one quotient bit per
//  cycle (skipped when a region is empty) and the result hand-off.
//  Synchronous active-low reset clears counters, sums and control state.
// ----------------------------------------------------------------------------
module aperture_photometry_sums_core import aps_pkg::*; #(
    parameter int MAX_SIDE         = MAX_SIDE_DEF,
    parameter int PIXEL_BITS       = PIXEL_BITS_DEF,
    parameter int RESULT_FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PIXEL_BITS-1:0]    s_pixel_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SUM_W-1:0]         m_inner_sum,
    output logic [CNT_W-1:0]         m_inner_count,
    output logic [SUM_W-1:0]         m_annulus_sum,
    output logic [CNT_W-1:0]         m_annulus_count,
    output logic signed [DIFF_W-1:0] m_mean_difference,
    output logic                     m_empty_region
);

    logic [CFG_W-1:0]  center_x_reg, center_y_reg;
    logic [CFG_W-1:0]  inner_radius_reg, outer_radius_reg;
    logic [SIDE_W-1:0] image_width_reg, image_height_reg;
    logic [IDX_W-1:0]  reg_idx;
    logic              wr_en;

    aps_cmd_t  cmd;
    aps_stat_t stat;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg     <= RST_CENTER_X;
            center_y_reg     <= RST_CENTER_Y;
            inner_radius_reg <= RST_INNER_RADIUS;
            outer_radius_reg <= RST_OUTER_RADIUS;
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CENTER_X:     center_x_reg     <= pwdata[CFG_W-1:0];
                REG_CENTER_Y:     center_y_reg     <= pwdata[CFG_W-1:0];
                REG_INNER_RADIUS: inner_radius_reg <= pwdata[CFG_W-1:0];
                REG_OUTER_RADIUS: outer_radius_reg <= pwdata[CFG_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[SIDE_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[SIDE_W-1:0];
                default: begin
                    center_x_reg <= center_x_reg;
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CENTER_X:     prdata = DATA_W'(center_x_reg);
            REG_CENTER_Y:     prdata = DATA_W'(center_y_reg);
            REG_INNER_RADIUS: prdata = DATA_W'(inner_radius_reg);
            REG_OUTER_RADIUS: prdata = DATA_W'(outer_radius_reg);
            REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    assign s_ready = cmd.ready;

    aps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .cmd     (cmd)
    );

    aps_dp #(
        .MAX_SIDE         (MAX_SIDE),
        .PIXEL_BITS       (PIXEL_BITS),
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_valid           (s_valid),
        .s_pixel_value     (s_pixel_value),
        .center_x          (center_x_reg),
        .center_y          (center_y_reg),
        .inner_radius      (inner_radius_reg),
        .outer_radius      (outer_radius_reg),
        .image_width       (image_width_reg),
        .image_height      (image_height_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_inner_sum       (m_inner_sum),
        .m_inner_count     (m_inner_count),
        .m_annulus_sum     (m_annulus_sum),
        .m_annulus_count   (m_annulus_count),
        .m_mean_difference (m_mean_difference),
        .m_empty_region    (m_empty_region)
    );

endmodule

// ===== sv/aps_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aperture photometry sums - divider
// Restoring unsigned divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module aps_div #(
    parameter int DW = 48,
    parameter int VW = 25
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int KW = $clog2(DW);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [KW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   trial;
    logic [VW:0]   trial_sub;
    logic          ge;
    logic [VW-1:0] rem_next;

    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign ge        = trial >= {1'b0, dvs_reg};
    assign rem_next  = ge ? trial_sub[VW-1:0] : trial[VW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            cnt_reg <= KW'(DW - 1);
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/aps_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aperture photometry sums - datapath
// Position counters, distance pipeline, accumulators, shared divider and
// result register.
// ----------------------------------------------------------------------------
module aps_dp import aps_pkg::*; #(
    parameter int MAX_SIDE         = MAX_SIDE_DEF,
    parameter int PIXEL_BITS       = PIXEL_BITS_DEF,
    parameter int RESULT_FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  aps_cmd_t                 cmd,
    output aps_stat_t                stat,
    input  logic                     s_valid,
    input  logic [PIXEL_BITS-1:0]    s_pixel_value,
    input  logic [CFG_W-1:0]         center_x,
    input  logic [CFG_W-1:0]         center_y,
    input  logic [CFG_W-1:0]         inner_radius,
    input  logic [CFG_W-1:0]         outer_radius,
    input  logic [SIDE_W-1:0]        image_width,
    input  logic [SIDE_W-1:0]        image_height,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SUM_W-1:0]         m_inner_sum,
    output logic [CNT_W-1:0]         m_inner_count,
    output logic [SUM_W-1:0]         m_annulus_sum,
    output logic [CNT_W-1:0]         m_annulus_count,
    output logic signed [DIFF_W-1:0] m_mean_difference,
    output logic                     m_empty_region
);

    localparam int CW  = $clog2(MAX_SIDE);
    localparam int PW  = CW + 4;
    localparam int XW  = (PW > CFG_W) ? PW : CFG_W;
    localparam int SQW = 2 * XW;
    localparam int D2W = SQW + 1;
    localparam int DW  = SUM_W + RESULT_FRAC_BITS;

    logic [CW-1:0] col_reg, row_reg;
    logic [CW-1:0] last_col, last_row;
    logic          end_row, accept;

    logic [XW-1:0] col_q, row_q, cx, cy, dx, dy;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  last1_reg, last2_reg, last3_reg;
    logic [XW-1:0]         dx_reg, dy_reg;
    logic [SQW-1:0]        sqx_reg, sqy_reg;
    logic [D2W-1:0]        d2;
    logic                  inner3_reg, ann3_reg;
    logic [PIXEL_BITS-1:0] pix1_reg, pix2_reg, pix3_reg;
    logic [2*CFG_W-1:0]    r1sq_reg, r2sq_reg;
    logic                  acc_done_reg;

    logic [SUM_W-1:0] inner_acc_reg, ann_acc_reg;
    logic [CNT_W-1:0] inner_cnt_reg, ann_cnt_reg;

    logic [DW-1:0]     div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    logic              div_done;
    logic [DW-1:0]     div_quotient;
    logic [DIFF_W-1:0] mean_in_reg;
    logic [DIFF_W-1:0] diff;
    logic              empty;

    logic                     m_valid_reg;
    logic [SUM_W-1:0]         m_inner_sum_reg, m_annulus_sum_reg;
    logic [CNT_W-1:0]         m_inner_count_reg, m_annulus_count_reg;
    logic signed [DIFF_W-1:0] m_mean_difference_reg;
    logic                     m_empty_region_reg;

    // zero or oversize side counts as MAX_SIDE
    always_comb begin
        if (image_width == '0 || 32'(image_width) > 32'(MAX_SIDE)) begin
            last_col = CW'(MAX_SIDE - 1);
        end else begin
            last_col = CW'(32'(image_width) - 32'd1);
        end
        if (image_height == '0 || 32'(image_height) > 32'(MAX_SIDE)) begin
            last_row = CW'(MAX_SIDE - 1);
        end else begin
            last_row = CW'(32'(image_height) - 32'd1);
        end
    end

    assign end_row = col_reg >= last_col;
    assign accept  = s_valid && cmd.ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (stat.end_frame) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (end_row) begin
                col_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    assign col_q = XW'({col_reg, 4'b0000});
    assign row_q = XW'({row_reg, 4'b0000});
    assign cx    = XW'(center_x);
    assign cy    = XW'(center_y);
    assign dx    = (col_q >= cx) ? (col_q - cx) : (cx - col_q);
    assign dy    = (row_q >= cy) ? (row_q - cy) : (cy - row_q);
    assign d2    = D2W'(sqx_reg) + D2W'(sqy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            acc_done_reg <= 1'b0;
        end else begin
            v1_reg       <= accept;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            acc_done_reg <= v3_reg && last3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        r1sq_reg  <= (2*CFG_W)'(inner_radius) * (2*CFG_W)'(inner_radius);
        r2sq_reg  <= (2*CFG_W)'(outer_radius) * (2*CFG_W)'(outer_radius);
        dx_reg    <= dx;
        dy_reg    <= dy;
        pix1_reg  <= s_pixel_value;
        last1_reg <= stat.end_frame;
        sqx_reg   <= SQW'(dx_reg) * SQW'(dx_reg);
        sqy_reg   <= SQW'(dy_reg) * SQW'(dy_reg);
        pix2_reg  <= pix1_reg;
        last2_reg <= last1_reg;
        inner3_reg <= d2 < D2W'(r1sq_reg);
        ann3_reg   <= !(d2 < D2W'(r1sq_reg)) && (d2 < D2W'(r2sq_reg));
        pix3_reg   <= pix2_reg;
        last3_reg  <= last2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            inner_acc_reg <= '0;
            ann_acc_reg   <= '0;
            inner_cnt_reg <= '0;
            ann_cnt_reg   <= '0;
        end else if (v3_reg) begin
            if (inner3_reg) begin
                inner_acc_reg <= inner_acc_reg + SUM_W'(pix3_reg);
                inner_cnt_reg <= inner_cnt_reg + 1'b1;
            end else if (ann3_reg) begin
                ann_acc_reg <= ann_acc_reg + SUM_W'(pix3_reg);
                ann_cnt_reg <= ann_cnt_reg + 1'b1;
            end
        end
    end

    assign div_dividend = cmd.div_annulus ? (DW'(ann_acc_reg) << RESULT_FRAC_BITS)
                                          : (DW'(inner_acc_reg) << RESULT_FRAC_BITS);
    assign div_divisor  = cmd.div_annulus ? ann_cnt_reg : inner_cnt_reg;

    aps_div #(
        .DW (DW),
        .VW (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (cmd.latch_inner) begin
            mean_in_reg <= div_quotient[DIFF_W-1:0];
        end
    end

    assign empty = (inner_cnt_reg == '0) || (ann_cnt_reg == '0);
    assign diff  = empty ? '0 : (mean_in_reg - div_quotient[DIFF_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_inner_sum_reg       <= inner_acc_reg;
            m_inner_count_reg     <= inner_cnt_reg;
            m_annulus_sum_reg     <= ann_acc_reg;
            m_annulus_count_reg   <= ann_cnt_reg;
            m_mean_difference_reg <= diff;
            m_empty_region_reg    <= empty;
        end
    end

    assign stat.end_frame = end_row && (row_reg >= last_row);
    assign stat.acc_done  = acc_done_reg;
    assign stat.empty     = empty;
    assign stat.div_done  = div_done;
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid           = m_valid_reg;
    assign m_inner_sum       = m_inner_sum_reg;
    assign m_inner_count     = m_inner_count_reg;
    assign m_annulus_sum     = m_annulus_sum_reg;
    assign m_annulus_count   = m_annulus_count_reg;
    assign m_mean_difference = m_mean_difference_reg;
    assign m_empty_region    = m_empty_region_reg;

endmodule

// ===== sv/aps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aperture photometry sums - controller
// Sequences pixel intake, pipeline drain, the two mean divisions and the
// hand-off of each frame's result.
// ----------------------------------------------------------------------------
`include "aperture_photometry_sums_core_macros.svh"

module aps_ctrl import aps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  aps_stat_t stat,
    output aps_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DRAIN,
        ST_DIV_IN,
        ST_DIV_AN,
        ST_OUT
    } state_t;

    state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            unique case (state_reg)
                ST_RUN: begin
                    if (s_valid && stat.end_frame) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (stat.acc_done) begin
                        state_reg <= stat.empty ? ST_OUT : ST_DIV_IN;
                    end
                end
                ST_DIV_IN: begin
                    if (stat.div_done) begin
                        state_reg <= ST_DIV_AN;
                    end
                end
                ST_DIV_AN: begin
                    if (stat.div_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (stat.out_free) begin
                        state_reg <= ST_RUN;
                    end
                end
                default: begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    always_comb begin
        cmd       = '0;
        cmd.ready = (state_reg == ST_RUN);
        unique case (state_reg)
            ST_DRAIN: begin
                cmd.div_start = stat.acc_done && !stat.empty;
            end
            ST_DIV_IN: begin
                cmd.latch_inner = stat.div_done;
                cmd.div_start   = stat.div_done;
                cmd.div_annulus = stat.div_done;
            end
            ST_OUT: begin
                cmd.load_out = stat.out_free;
                cmd.clear    = stat.out_free;
            end
            default: begin
                cmd.div_annulus = 1'b0;
            end
        endcase
    end

    `APS_ASSERT_NEXT(a_last_beat_stalls, aclk, aresetn, s_valid && cmd.ready && stat.end_frame, !cmd.ready, "intake still open after last beat of frame")
    `APS_ASSERT_SAME(a_no_div_in_run, aclk, aresetn, state_reg == ST_RUN, !stat.div_done, "divider finished while taking pixels")
    `APS_ASSERT_SAME(a_no_acc_done_in_run, aclk, aresetn, state_reg == ST_RUN, !stat.acc_done, "frame end reached accumulators during intake")
    `APS_ASSERT_NEXT(a_load_clears, aclk, aresetn, cmd.load_out, state_reg == ST_RUN, "result load did not return to intake")

endmodule
